[hdl/gst_pkg.sv]
// ----------------------------------------------------------------------------
// GPS sector timer package
// Shared widths, codes, state type, request/response structs and a bounding box test.
// ----------------------------------------------------------------------------
package gst_pkg;

  localparam int COORD_W = 32;
  localparam int DIFF_W  = 33;
  localparam int ACC_W   = 37;
  localparam int LOW_W   = 33;
  localparam int PROD_W  = ACC_W + LOW_W;
  localparam int SUM_W   = 48;
  localparam int CNT_W   = 32;
  localparam int TIME_W  = 32;
  localparam int CFG_W   = 64;
  localparam int CFG_IDX_W = 3;
  localparam int NUM_LINES = 3;
  localparam int COLLINEAR_EPS = 100000;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_LINE1_A = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LINE1_B = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LINE2_A = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LINE2_B = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_LINE3_A = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_LINE3_B = 3'd5;

  // Orientation codes.
  localparam logic [1:0] ORI_COLL = 2'd0;
  localparam logic [1:0] ORI_POS  = 2'd1;
  localparam logic [1:0] ORI_NEG  = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_OR_START,
    S_OR_WAIT,
    S_CROSS,
    S_DIV_START,
    S_DIV_WAIT,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] lat;
    logic signed [COORD_W-1:0] lon;
  } point_t;

  typedef struct packed {
    logic                     start;
    logic signed [DIFF_W-1:0] m1;
    logic signed [DIFF_W-1:0] n1;
    logic signed [DIFF_W-1:0] m2;
    logic signed [DIFF_W-1:0] n2;
  } orient_req_t;

  typedef struct packed {
    logic       done;
    logic [1:0] code;
  } orient_rsp_t;

  typedef struct packed {
    logic             start;
    logic [SUM_W-1:0] dividend;
    logic [CNT_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [SUM_W-1:0] quot;
  } div_rsp_t;

  // True when q lies inside the bounding box spanned by p and r.
  function automatic logic in_bbox(point_t p, point_t q, point_t r);
    logic signed [COORD_W-1:0] lo_lon;
    logic signed [COORD_W-1:0] hi_lon;
    logic signed [COORD_W-1:0] lo_lat;
    logic signed [COORD_W-1:0] hi_lat;
    lo_lon = (p.lon < r.lon) ? p.lon : r.lon;
    hi_lon = (p.lon < r.lon) ? r.lon : p.lon;
    lo_lat = (p.lat < r.lat) ? p.lat : r.lat;
    hi_lat = (p.lat < r.lat) ? r.lat : p.lat;
    return (q.lon <= hi_lon) && (q.lon >= lo_lon) &&
           (q.lat <= hi_lat) && (q.lat >= lo_lat);
  endfunction

endpackage

[hdl/gst_if.sv]
// ----------------------------------------------------------------------------
// GPS sector timer channels
// Valid/ready channels for input items and result items.
// ----------------------------------------------------------------------------
interface gst_in_if;
  logic        valid;
  logic        ready;
  logic        cmd;
  logic [31:0] stamp_ms;
  logic signed [30:0] fix_latitude;
  logic signed [31:0] fix_longitude;
  logic signed [15:0] speed_sample;

  modport source (output valid, cmd, stamp_ms, fix_latitude, fix_longitude,
                  speed_sample, input ready);
  modport sink   (input valid, cmd, stamp_ms, fix_latitude, fix_longitude,
                  speed_sample, output ready);
endinterface

interface gst_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  sector_id;
  logic [31:0] sector_time_ms;
  logic signed [15:0] avg_speed;

  modport source (output valid, sector_id, sector_time_ms, avg_speed, input ready);
  modport sink   (input valid, sector_id, sector_time_ms, avg_speed, output ready);
endinterface

[hdl/gst_orient.sv]
// ----------------------------------------------------------------------------
// Serial orientation unit
// Computes m1*n1 - m2*n2 one multiplier bit per cycle and classifies it.
// ----------------------------------------------------------------------------
module gst_orient (
  input  logic                clk,
  input  logic                rst_n,
  input  gst_pkg::orient_req_t req,
  output gst_pkg::orient_rsp_t rsp
);

  localparam int CW = $clog2(gst_pkg::DIFF_W + 1);

  logic                               busy_r, busy_nxt;
  logic                               fin_r, fin_nxt;
  logic [CW-1:0]                      cnt_r, cnt_nxt;
  logic signed [gst_pkg::DIFF_W-1:0]  a1_r, a1_nxt, a2_r, a2_nxt;
  logic [gst_pkg::DIFF_W-1:0]         b1_r, b1_nxt, b2_r, b2_nxt;
  logic signed [gst_pkg::ACC_W-1:0]   acc_r, acc_nxt;
  logic [gst_pkg::LOW_W-1:0]          lo_r, lo_nxt;

  logic signed [gst_pkg::DIFF_W+1:0]  p1, p2, t;
  logic signed [gst_pkg::ACC_W-1:0]   sum;
  logic                               last;
  logic signed [gst_pkg::PROD_W-1:0]  val;

  localparam logic signed [gst_pkg::PROD_W-1:0] EPS =
    gst_pkg::PROD_W'(gst_pkg::COLLINEAR_EPS);

  // One partial product pair per cycle; the sign bit weighs negative.
  always_comb begin
    p1   = b1_r[0] ? (gst_pkg::DIFF_W+2)'(a1_r) : '0;
    p2   = b2_r[0] ? (gst_pkg::DIFF_W+2)'(a2_r) : '0;
    last = (cnt_r == CW'(gst_pkg::DIFF_W - 1));
    t    = last ? (p2 - p1) : (p1 - p2);
    sum  = acc_r + gst_pkg::ACC_W'(t);
  end

  // Sequencing of the shift-add loop.
  always_comb begin
    busy_nxt = busy_r;
    fin_nxt  = 1'b0;
    cnt_nxt  = cnt_r;
    a1_nxt   = a1_r;
    a2_nxt   = a2_r;
    b1_nxt   = b1_r;
    b2_nxt   = b2_r;
    acc_nxt  = acc_r;
    lo_nxt   = lo_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      a1_nxt   = req.m1;
      a2_nxt   = req.m2;
      b1_nxt   = req.n1;
      b2_nxt   = req.n2;
      acc_nxt  = '0;
      lo_nxt   = '0;
    end else if (busy_r) begin
      acc_nxt = sum >>> 1;
      lo_nxt  = {sum[0], lo_r[gst_pkg::LOW_W-1:1]};
      b1_nxt  = b1_r >> 1;
      b2_nxt  = b2_r >> 1;
      cnt_nxt = cnt_r + CW'(1);
      if (last) begin
        busy_nxt = 1'b0;
        fin_nxt  = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      fin_r  <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      fin_r  <= fin_nxt;
    end
    cnt_r <= cnt_nxt;
    a1_r  <= a1_nxt;
    a2_r  <= a2_nxt;
    b1_r  <= b1_nxt;
    b2_r  <= b2_nxt;
    acc_r <= acc_nxt;
    lo_r  <= lo_nxt;
  end

  // Classify the finished product; small magnitudes count as collinear.
  always_comb begin
    val      = {acc_r, lo_r};
    rsp.done = fin_r;
    if ((val < EPS) && (val > -EPS)) begin
      rsp.code = gst_pkg::ORI_COLL;
    end else if (val > 0) begin
      rsp.code = gst_pkg::ORI_POS;
    end else begin
      rsp.code = gst_pkg::ORI_NEG;
    end
  end

endmodule

[hdl/gst_div.sv]
// ----------------------------------------------------------------------------
// Serial divider
// Restoring unsigned division, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module gst_div (
  input  logic             clk,
  input  logic             rst_n,
  input  gst_pkg::div_req_t req,
  output gst_pkg::div_rsp_t rsp
);

  localparam int CW = $clog2(gst_pkg::SUM_W);

  logic                       busy_r, busy_nxt;
  logic                       done_r, done_nxt;
  logic [CW-1:0]              cnt_r, cnt_nxt;
  logic [gst_pkg::SUM_W-1:0]  q_r, q_nxt;
  logic [gst_pkg::CNT_W-1:0]  rem_r, rem_nxt;
  logic [gst_pkg::CNT_W-1:0]  dv_r, dv_nxt;

  logic [gst_pkg::CNT_W:0]    rsh, diff;
  logic                       ge;

  // Trial subtract of the shifted remainder.
  always_comb begin
    rsh  = {rem_r, q_r[gst_pkg::SUM_W-1]};
    diff = rsh - {1'b0, dv_r};
    ge   = (rsh >= {1'b0, dv_r});
  end

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    dv_nxt   = dv_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      q_nxt    = req.dividend;
      rem_nxt  = '0;
      dv_nxt   = req.divisor;
    end else if (busy_r) begin
      rem_nxt = ge ? diff[gst_pkg::CNT_W-1:0] : rsh[gst_pkg::CNT_W-1:0];
      q_nxt   = {q_r[gst_pkg::SUM_W-2:0], ge};
      cnt_nxt = cnt_r + CW'(1);
      if (cnt_r == CW'(gst_pkg::SUM_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    cnt_r <= cnt_nxt;
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    dv_r  <= dv_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.quot = q_r;

endmodule

[hdl/gps_sector_crossing_timer.sv]
// ----------------------------------------------------------------------------
// GPS sector crossing timer
// Sector timing from GPS fixes and speed samples.
// ----------------------------------------------------------------------------
//  Channel   Direction  Transfer moves
//  in_ch     sink       one GPS fix or one speed sample
//  out_ch    source     sector number, sector time, mean speed (per fix)
//  cfg_*     write      boundary line endpoints, six 64-bit registers
//
// A speed sample is taken in the idle state and leaves it idle. A fix raises
// its result after four serial cross products, a decision state, then the
// 48-bit serial divide and finish when a boundary is tested, and after the
// divide and finish alone otherwise; with no samples in the sector the divide
// is skipped. Reset is synchronous and clears all control and sector state.
// A new item is taken while a result waits; a finished fix holds until the
// output register is free.
// ----------------------------------------------------------------------------
module gps_sector_crossing_timer #(
  parameter int NUM_SECTORS = 3
) (
  input  logic                          clk,
  input  logic                          rst_n,
  gst_in_if.sink                        in_ch,
  gst_out_if.source                     out_ch,
  input  logic                          cfg_we,
  input  logic [gst_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [gst_pkg::CFG_W-1:0]     cfg_data
);

  gst_pkg::state_t state_r, state_nxt;

  logic [gst_pkg::CFG_W-1:0]  line_a_r [gst_pkg::NUM_LINES];
  logic [gst_pkg::CFG_W-1:0]  line_b_r [gst_pkg::NUM_LINES];

  gst_pkg::point_t            prev_r, pa_r, pb_r, pc_r, pd_r;
  gst_pkg::point_t            cur_pt, op_p, op_q, op_r;
  logic                       have_prev_r, start_valid_r;
  logic [1:0]                 sector_r;
  logic [gst_pkg::TIME_W-1:0] start_ms_r, stamp_r;
  logic signed [gst_pkg::SUM_W-1:0] sum_r;
  logic [gst_pkg::CNT_W-1:0]  cnt_r;
  logic [1:0]                 k_r;
  logic [1:0]                 ori_r [4];

  logic                       out_valid_r;
  logic [2:0]                 out_id_r;
  logic [gst_pkg::TIME_W-1:0] out_time_r;
  logic signed [15:0]         out_mean_r;

  logic                       acc_in, out_free, crossing, test_line;
  logic [gst_pkg::CFG_W-1:0]  sel_a, sel_b;
  logic signed [gst_pkg::SUM_W:0] samp_sum;
  logic signed [gst_pkg::SUM_W-1:0] samp_sat;
  logic [gst_pkg::SUM_W-1:0]  sum_mag;
  logic [1:0]                 sector_inc;
  logic signed [15:0]         mean;

  gst_pkg::orient_req_t       ori_req;
  gst_pkg::orient_rsp_t       ori_rsp;
  gst_pkg::div_req_t          div_req;
  gst_pkg::div_rsp_t          div_rsp;

  gst_orient u_orient (.clk(clk), .rst_n(rst_n), .req(ori_req), .rsp(ori_rsp));
  gst_div    u_div    (.clk(clk), .rst_n(rst_n), .req(div_req), .rsp(div_rsp));

  assign acc_in   = in_ch.valid && in_ch.ready;
  assign out_free = !out_valid_r || out_ch.ready;
  assign cur_pt.lat = gst_pkg::COORD_W'(in_ch.fix_latitude);
  assign cur_pt.lon = in_ch.fix_longitude;
  assign test_line  = have_prev_r && (sector_r < 2'(gst_pkg::NUM_LINES));

  // Boundary line of the current sector.
  always_comb begin
    case (sector_r)
      2'd0:    begin sel_a = line_a_r[0]; sel_b = line_b_r[0]; end
      2'd1:    begin sel_a = line_a_r[1]; sel_b = line_b_r[1]; end
      default: begin sel_a = line_a_r[2]; sel_b = line_b_r[2]; end
    endcase
  end

  // Operands of the four orientation tests.
  always_comb begin
    case (k_r)
      2'd0:    begin op_p = pa_r; op_q = pb_r; op_r = pc_r; end
      2'd1:    begin op_p = pa_r; op_q = pb_r; op_r = pd_r; end
      2'd2:    begin op_p = pc_r; op_q = pd_r; op_r = pa_r; end
      default: begin op_p = pc_r; op_q = pd_r; op_r = pb_r; end
    endcase
    ori_req.start = (state_r == gst_pkg::S_OR_START);
    ori_req.m1 = gst_pkg::DIFF_W'(op_q.lat) - gst_pkg::DIFF_W'(op_p.lat);
    ori_req.n1 = gst_pkg::DIFF_W'(op_r.lon) - gst_pkg::DIFF_W'(op_q.lon);
    ori_req.m2 = gst_pkg::DIFF_W'(op_q.lon) - gst_pkg::DIFF_W'(op_p.lon);
    ori_req.n2 = gst_pkg::DIFF_W'(op_r.lat) - gst_pkg::DIFF_W'(op_q.lat);
  end

  // Segment crossing decision, collinear cases included.
  always_comb begin
    crossing = ((ori_r[0] != ori_r[1]) && (ori_r[2] != ori_r[3])) ||
               ((ori_r[0] == gst_pkg::ORI_COLL) && gst_pkg::in_bbox(pa_r, pc_r, pb_r)) ||
               ((ori_r[1] == gst_pkg::ORI_COLL) && gst_pkg::in_bbox(pa_r, pd_r, pb_r)) ||
               ((ori_r[2] == gst_pkg::ORI_COLL) && gst_pkg::in_bbox(pc_r, pa_r, pd_r)) ||
               ((ori_r[3] == gst_pkg::ORI_COLL) && gst_pkg::in_bbox(pc_r, pb_r, pd_r));
    sector_inc = (({1'b0, sector_r} + 3'd1) >= 3'(NUM_SECTORS)) ? 2'd0 : sector_r + 2'd1;
  end

  // Saturating speed sum and divider operands.
  always_comb begin
    samp_sum = (gst_pkg::SUM_W+1)'(sum_r) + (gst_pkg::SUM_W+1)'(in_ch.speed_sample);
    if (samp_sum[gst_pkg::SUM_W] != samp_sum[gst_pkg::SUM_W-1]) begin
      samp_sat = samp_sum[gst_pkg::SUM_W] ? {1'b1, {(gst_pkg::SUM_W-1){1'b0}}}
                                          : {1'b0, {(gst_pkg::SUM_W-1){1'b1}}};
    end else begin
      samp_sat = samp_sum[gst_pkg::SUM_W-1:0];
    end
    sum_mag = sum_r[gst_pkg::SUM_W-1] ? gst_pkg::SUM_W'(-sum_r) : gst_pkg::SUM_W'(sum_r);
    div_req.start    = (state_r == gst_pkg::S_DIV_START) && (cnt_r != '0);
    div_req.dividend = sum_mag;
    div_req.divisor  = cnt_r;
  end

  // Clamp the quotient to the Q8.8 range and apply the sign.
  always_comb begin
    if (cnt_r == '0) begin
      mean = '0;
    end else if (sum_r[gst_pkg::SUM_W-1]) begin
      mean = (div_rsp.quot > gst_pkg::SUM_W'(32768)) ? 16'sh8000
                                                     : 16'(-div_rsp.quot[15:0]);
    end else begin
      mean = (div_rsp.quot > gst_pkg::SUM_W'(32767)) ? 16'sh7FFF
                                                     : 16'(div_rsp.quot[15:0]);
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      gst_pkg::S_IDLE: begin
        if (acc_in && !in_ch.cmd) begin
          state_nxt = test_line ? gst_pkg::S_OR_START : gst_pkg::S_DIV_START;
        end
      end
      gst_pkg::S_OR_START: state_nxt = gst_pkg::S_OR_WAIT;
      gst_pkg::S_OR_WAIT: begin
        if (ori_rsp.done) begin
          state_nxt = (k_r == 2'd3) ? gst_pkg::S_CROSS : gst_pkg::S_OR_START;
        end
      end
      gst_pkg::S_CROSS: state_nxt = gst_pkg::S_DIV_START;
      gst_pkg::S_DIV_START: begin
        state_nxt = (cnt_r != '0) ? gst_pkg::S_DIV_WAIT : gst_pkg::S_FINISH;
      end
      gst_pkg::S_DIV_WAIT: begin
        if (div_rsp.done) state_nxt = gst_pkg::S_FINISH;
      end
      gst_pkg::S_FINISH: begin
        if (out_free) state_nxt = gst_pkg::S_IDLE;
      end
      default: state_nxt = gst_pkg::S_IDLE;
    endcase
  end

  // Handshake outputs.
  always_comb begin
    in_ch.ready           = (state_r == gst_pkg::S_IDLE);
    out_ch.valid          = out_valid_r;
    out_ch.sector_id      = out_id_r;
    out_ch.sector_time_ms = out_time_r;
    out_ch.avg_speed      = out_mean_r;
  end

  // Control and sector state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= gst_pkg::S_IDLE;
      have_prev_r   <= 1'b0;
      start_valid_r <= 1'b0;
      sector_r      <= '0;
      start_ms_r    <= '0;
      sum_r         <= '0;
      cnt_r         <= '0;
      prev_r        <= '0;
      k_r           <= '0;
      out_valid_r   <= 1'b0;
      for (int i = 0; i < gst_pkg::NUM_LINES; i++) begin
        line_a_r[i] <= '0;
        line_b_r[i] <= '0;
      end
    end else begin
      state_r <= state_nxt;

      // Configuration writes.
      if (cfg_we) begin
        unique case (cfg_index)
          gst_pkg::CFG_LINE1_A: line_a_r[0] <= cfg_data;
          gst_pkg::CFG_LINE1_B: line_b_r[0] <= cfg_data;
          gst_pkg::CFG_LINE2_A: line_a_r[1] <= cfg_data;
          gst_pkg::CFG_LINE2_B: line_b_r[1] <= cfg_data;
          gst_pkg::CFG_LINE3_A: line_a_r[2] <= cfg_data;
          gst_pkg::CFG_LINE3_B: line_b_r[2] <= cfg_data;
          default: ;
        endcase
      end

      // Accepted items.
      if (acc_in) begin
        if (in_ch.cmd) begin
          sum_r <= samp_sat;
          if (cnt_r != '1) cnt_r <= cnt_r + gst_pkg::CNT_W'(1);
        end else begin
          if (!start_valid_r) begin
            start_ms_r    <= in_ch.stamp_ms;
            start_valid_r <= 1'b1;
          end
          prev_r      <= cur_pt;
          have_prev_r <= 1'b1;
          k_r         <= '0;
        end
      end

      if ((state_r == gst_pkg::S_OR_WAIT) && ori_rsp.done) begin
        k_r <= k_r + 2'd1;
      end

      if ((state_r == gst_pkg::S_CROSS) && crossing) begin
        sector_r   <= sector_inc;
        sum_r      <= '0;
        cnt_r      <= '0;
        start_ms_r <= stamp_r;
      end

      // Output register.
      if ((state_r == gst_pkg::S_FINISH) && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (acc_in && !in_ch.cmd) begin
      stamp_r <= in_ch.stamp_ms;
      pa_r    <= sel_a;
      pb_r    <= sel_b;
      pc_r    <= prev_r;
      pd_r    <= cur_pt;
    end
    if ((state_r == gst_pkg::S_OR_WAIT) && ori_rsp.done) begin
      ori_r[k_r] <= ori_rsp.code;
    end
    if ((state_r == gst_pkg::S_FINISH) && out_free) begin
      out_id_r   <= {1'b0, sector_r} + 3'd1;
      out_time_r <= stamp_r - start_ms_r;
      out_mean_r <= mean;
    end
  end

endmodule

[hdl/gst_checker.sv]
// ----------------------------------------------------------------------------
// GPS sector timer checker
// Port-level assertions, bound to the top level.
// ----------------------------------------------------------------------------
module gst_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        in_cmd,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  out_sector_id,
  input logic [31:0] out_sector_time_ms
);

  // A pending result holds until its transfer.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_sector_time_ms))
    else $error("result dropped or changed while stalled");

  // A fix occupies the block, so input is not ready right after it.
  a_fix_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && !in_cmd |=> !in_ready)
    else $error("input ready right after a fix transfer");

  // Sector numbers count from one and stay within four.
  a_sector_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_sector_id != 3'd0) && (out_sector_id <= 3'd4))
    else $error("sector number out of range");

  // Reset leaves no result pending.
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind gps_sector_crossing_timer gst_checker u_gst_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_ch.valid),
  .in_ready          (in_ch.ready),
  .in_cmd            (in_ch.cmd),
  .out_valid         (out_ch.valid),
  .out_ready         (out_ch.ready),
  .out_sector_id     (out_ch.sector_id),
  .out_sector_time_ms(out_ch.sector_time_ms)
);
